### hdl/psu_pkg.sv
// Shared types and constants for the particle swarm update engine.
// Depends on nothing; imported by psu_ctrl, psu_dp, the top level and the bench.
package psu_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int MAX_AXES      = 8;
  localparam int PA_W          = $clog2(MAX_PARTICLES);
  localparam int AXIS_W        = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int ADDR_W        = PA_W + AXIS_W;

  localparam logic signed [31:0] COST_NONE = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_LIMITS = 2'd0,
    OP_INIT   = 2'd1,
    OP_COST   = 2'd2,
    OP_UPDATE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_AXES   = 3'd0,
    REG_WEIGHT = 3'd1,
    REG_C1     = 3'd2,
    REG_C2     = 3'd3,
    REG_TARGET = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [5:0]         particle_index;
    logic [2:0]         axis_index;
    logic signed [31:0] limit_first;
    logic signed [31:0] limit_second;
    logic signed [31:0] cost;
    logic [15:0]        rand_one;
    logic [15:0]        rand_two;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_axis;
    logic signed [31:0] new_position;
    logic signed [31:0] best_cost;
    logic               target_reached;
    logic               status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]         axes_in_use;
    logic [15:0]        inertia_weight;
    logic [15:0]        self_gain;
    logic [15:0]        swarm_gain;
    logic signed [31:0] target_cost;
  } cfg_t;

  typedef enum logic [4:0] {
    STEP_NONE     = 5'd0,
    STEP_LOAD     = 5'd1,
    STEP_LIMITS   = 5'd2,
    STEP_INIT_MUL = 5'd3,
    STEP_INIT_WR  = 5'd4,
    STEP_PBC_RD   = 5'd5,
    STEP_CMP      = 5'd6,
    STEP_COPY_RD  = 5'd7,
    STEP_COPY_WR  = 5'd8,
    STEP_K1       = 5'd9,
    STEP_K2       = 5'd10,
    STEP_RD       = 5'd11,
    STEP_M1       = 5'd12,
    STEP_M2       = 5'd13,
    STEP_M3       = 5'd14,
    STEP_M4       = 5'd15,
    STEP_UPD      = 5'd16
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
    logic     emit;
    logic     next_axis;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    err;
    logic    axis_last;
    logic    copy_any;
    logic    out_busy;
  } stat_t;

endpackage

### hdl/psu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/psu_ctrl.sv
// Sequencer for the particle swarm update engine: walks each opcode
// through its datapath steps. Depends on psu_pkg.
module psu_ctrl import psu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_DEC  = 18'h00002,
    S_LIM  = 18'h00004,
    S_IMUL = 18'h00008,
    S_IWR  = 18'h00010,
    S_PRD  = 18'h00020,
    S_CMP  = 18'h00040,
    S_CRD  = 18'h00080,
    S_CWR  = 18'h00100,
    S_K1   = 18'h00200,
    S_K2   = 18'h00400,
    S_RD   = 18'h00800,
    S_M1   = 18'h01000,
    S_M2   = 18'h02000,
    S_M3   = 18'h04000,
    S_M4   = 18'h08000,
    S_UPD  = 18'h10000,
    S_WAIT = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.step      = STEP_NONE;
    cmd.emit      = 1'b0;
    cmd.next_axis = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step  = STEP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (st.err) begin
          cmd.emit  = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          case (st.op)
            OP_LIMITS: state_nxt = S_LIM;
            OP_INIT:   state_nxt = S_IMUL;
            OP_COST:   state_nxt = S_PRD;
            OP_UPDATE: state_nxt = S_K1;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LIM: begin
        cmd.step  = STEP_LIMITS;
        cmd.emit  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_IMUL: begin
        cmd.step  = STEP_INIT_MUL;
        state_nxt = S_IWR;
      end
      S_IWR: begin
        cmd.step  = STEP_INIT_WR;
        cmd.emit  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_PRD: begin
        cmd.step  = STEP_PBC_RD;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.step = STEP_CMP;
        if (st.copy_any) begin
          state_nxt = S_CRD;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_CRD: begin
        cmd.step  = STEP_COPY_RD;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cmd.step = STEP_COPY_WR;
        if (st.axis_last) begin
          cmd.emit  = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          cmd.next_axis = 1'b1;
          state_nxt     = S_CRD;
        end
      end
      S_K1: begin
        cmd.step  = STEP_K1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.step  = STEP_K2;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.step  = STEP_RD;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.step  = STEP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.step  = STEP_M2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.step  = STEP_M3;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.step  = STEP_M4;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.step  = STEP_UPD;
        cmd.emit  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        // hold until the result beat has left the output register
        if (!st.out_busy) begin
          if (st.op == OP_UPDATE && !st.err && !st.axis_last) begin
            cmd.next_axis = 1'b1;
            state_nxt     = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/psu_dp.sv
// Datapath of the particle swarm update engine: swarm memories, shared
// multiplier, accumulator, clamp and output register. Depends on psu_pkg, psu_ram.
module psu_dp import psu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output stat_t     st,
  input  in_item_t  in_data,
  input  cfg_t      cfg,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam logic signed [36:0] V_MAX = 37'sd2147483647;
  localparam logic signed [36:0] V_MIN = -37'sd2147483648;

  in_item_t           item_r;
  logic [AXIS_W-1:0]  axis_r;
  logic signed [31:0] gbc_r;
  logic signed [31:0] gbp_r  [MAX_AXES];
  logic signed [31:0] amin_r [MAX_AXES];
  logic signed [31:0] amax_r [MAX_AXES];
  logic signed [50:0] prod_r;
  logic signed [36:0] acc_r;
  logic [15:0]        k1_r, k2_r;
  logic signed [32:0] dpb_r, dgb_r;
  logic               pb_upd_r, gb_upd_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic [4:0]         eff;
  logic [AXIS_W-1:0]  n_m1;
  logic [AXIS_W-1:0]  a_idx;
  logic [AXIS_W-1:0]  ax;
  logic [ADDR_W-1:0]  addr;
  logic               err;
  logic               axis_last;
  logic [31:0]        pos_q, vel_q, pb_q, pbc_q;
  logic signed [16:0] ma;
  logic signed [33:0] mb;
  logic signed [50:0] prod_nxt;
  logic [31:0]        span;
  logic [31:0]        init_pos;
  logic signed [36:0] term;
  logic [31:0]        vnew;
  logic signed [32:0] xs, xmax, xmin;
  logic [31:0]        xc;
  logic               pb_lt, gb_lt;
  logic               pos_we, vel_we, pb_we, pbc_we;
  logic [31:0]        pos_wd, vel_wd, pb_wd, pbc_wd;

  // effective axis count: zero acts as one, oversize saturates
  always_comb begin
    if (cfg.axes_in_use == 4'd0) begin
      eff = 5'd1;
    end else if ({1'b0, cfg.axes_in_use} > 5'(MAX_AXES)) begin
      eff = 5'(MAX_AXES);
    end else begin
      eff = {1'b0, cfg.axes_in_use};
    end
  end

  assign n_m1      = AXIS_W'(eff - 5'd1);
  assign a_idx     = item_r.axis_index[AXIS_W-1:0];
  assign axis_last = (axis_r == n_m1);
  assign err = ({1'b0, item_r.particle_index} >= 7'(MAX_PARTICLES)) ||
               (((item_r.opcode == OP_LIMITS) || (item_r.opcode == OP_INIT)) &&
                (5'(item_r.axis_index) >= eff));
  assign ax   = (item_r.opcode == OP_INIT) ? a_idx : axis_r;
  assign addr = {item_r.particle_index[PA_W-1:0], ax};

  assign span     = amax_r[a_idx] - amin_r[a_idx];
  assign init_pos = amin_r[a_idx] + prod_r[47:16];

  // one shared multiplier; each product is registered before use
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.step)
      STEP_INIT_MUL: begin
        ma = {1'b0, item_r.rand_one};
        mb = {2'b00, span};
      end
      STEP_K1: begin
        ma = {1'b0, cfg.self_gain};
        mb = {18'd0, item_r.rand_one};
      end
      STEP_K2: begin
        ma = {1'b0, cfg.swarm_gain};
        mb = {18'd0, item_r.rand_two};
      end
      STEP_M1: begin
        ma = {1'b0, cfg.inertia_weight};
        mb = {{2{vel_q[31]}}, vel_q};
      end
      STEP_M2: begin
        ma = {1'b0, k1_r};
        mb = {dpb_r[32], dpb_r};
      end
      STEP_M3: begin
        ma = {1'b0, k2_r};
        mb = {dgb_r[32], dgb_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_nxt = ma * mb;
  assign term     = 37'(prod_r >>> 14);

  always_comb begin
    if (acc_r > V_MAX) begin
      vnew = 32'h7FFF_FFFF;
    end else if (acc_r < V_MIN) begin
      vnew = 32'h8000_0000;
    end else begin
      vnew = acc_r[31:0];
    end
  end

  assign xs   = $signed({pos_q[31], pos_q}) + $signed({vnew[31], vnew});
  assign xmax = {amax_r[axis_r][31], amax_r[axis_r]};
  assign xmin = {amin_r[axis_r][31], amin_r[axis_r]};

  always_comb begin
    if (xs > xmax) begin
      xc = amax_r[axis_r];
    end else if (xs < xmin) begin
      xc = amin_r[axis_r];
    end else begin
      xc = xs[31:0];
    end
  end

  assign pb_lt = item_r.cost < $signed(pbc_q);
  assign gb_lt = item_r.cost < gbc_r;

  assign pos_we = (cmd.step == STEP_INIT_WR) || (cmd.step == STEP_UPD);
  assign vel_we = pos_we;
  assign pb_we  = (cmd.step == STEP_INIT_WR) || ((cmd.step == STEP_COPY_WR) && pb_upd_r);
  assign pbc_we = (cmd.step == STEP_INIT_WR) || ((cmd.step == STEP_CMP) && pb_lt);
  assign pos_wd = (cmd.step == STEP_INIT_WR) ? init_pos : xc;
  assign vel_wd = (cmd.step == STEP_INIT_WR) ? 32'd0 : vnew;
  assign pb_wd  = (cmd.step == STEP_INIT_WR) ? init_pos : pos_q;
  assign pbc_wd = (cmd.step == STEP_INIT_WR) ? COST_NONE : item_r.cost;

  psu_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES * MAX_AXES)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(addr), .wdata(pos_wd), .raddr(addr), .rdata(pos_q)
  );

  psu_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES * MAX_AXES)) u_vel_ram (
    .clk(clk), .we(vel_we), .waddr(addr), .wdata(vel_wd), .raddr(addr), .rdata(vel_q)
  );

  psu_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES * MAX_AXES)) u_pb_ram (
    .clk(clk), .we(pb_we), .waddr(addr), .wdata(pb_wd), .raddr(addr), .rdata(pb_q)
  );

  psu_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pbc_ram (
    .clk(clk), .we(pbc_we), .waddr(item_r.particle_index[PA_W-1:0]), .wdata(pbc_wd),
    .raddr(item_r.particle_index[PA_W-1:0]), .rdata(pbc_q)
  );

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.step == STEP_LOAD) begin
      item_r <= in_data;
    end
    case (cmd.step)
      STEP_INIT_MUL, STEP_K1, STEP_K2, STEP_M1, STEP_M2, STEP_M3: prod_r <= prod_nxt;
      default: prod_r <= prod_r;
    endcase
    if (cmd.step == STEP_K2) begin
      k1_r <= prod_r[31:16];
    end
    if ((cmd.step == STEP_RD) && (axis_r == '0)) begin
      k2_r <= prod_r[31:16];
    end
    if (cmd.step == STEP_M1) begin
      dpb_r <= $signed({pb_q[31], pb_q}) - $signed({pos_q[31], pos_q});
      dgb_r <= $signed({gbp_r[axis_r][31], gbp_r[axis_r]}) - $signed({pos_q[31], pos_q});
    end
    case (cmd.step)
      STEP_M2: acc_r <= term;
      STEP_M3, STEP_M4: acc_r <= acc_r + term;
      default: acc_r <= acc_r;
    endcase
    if (cmd.step == STEP_CMP) begin
      pb_upd_r <= pb_lt;
      gb_upd_r <= gb_lt;
    end
    if (cmd.step == STEP_LIMITS) begin
      amin_r[a_idx] <= (item_r.limit_first < item_r.limit_second) ?
                       item_r.limit_first : item_r.limit_second;
      amax_r[a_idx] <= (item_r.limit_first < item_r.limit_second) ?
                       item_r.limit_second : item_r.limit_first;
    end
    if (cmd.emit) begin
      out_r.out_axis <= err ? item_r.axis_index :
                        (item_r.opcode == OP_UPDATE) ? 3'(axis_r) :
                        (item_r.opcode == OP_COST) ? 3'd0 : item_r.axis_index;
      out_r.new_position <= err ? 32'sd0 :
                            (cmd.step == STEP_INIT_WR) ? $signed(init_pos) :
                            (cmd.step == STEP_UPD) ? $signed(xc) : 32'sd0;
      out_r.best_cost      <= gbc_r;
      out_r.target_reached <= gbc_r < cfg.target_cost;
      out_r.status         <= err;
      out_r.last           <= (item_r.opcode == OP_UPDATE && !err) ? axis_last : 1'b1;
    end
  end

  // control state and the global best
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r      <= '0;
      gbc_r       <= COST_NONE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_AXES; i++) begin
        gbp_r[i] <= '0;
      end
    end else begin
      if (cmd.step == STEP_LOAD) begin
        axis_r <= '0;
      end else if (cmd.next_axis) begin
        axis_r <= axis_r + 1'b1;
      end
      if ((cmd.step == STEP_CMP) && gb_lt) begin
        gbc_r <= item_r.cost;
      end
      if ((cmd.step == STEP_COPY_WR) && gb_upd_r) begin
        gbp_r[axis_r] <= pos_q;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_data    = out_r;
  assign out_valid   = out_valid_r;
  assign st.op       = item_r.opcode;
  assign st.err      = err;
  assign st.axis_last = axis_last;
  assign st.copy_any = pb_lt || gb_lt;
  assign st.out_busy = out_valid_r && !out_ready;

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r)
    else $error("result beat loaded over an undelivered one");

  a_gbest_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> gbc_r <= $past(gbc_r))
    else $error("global best cost increased");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (item_r.opcode == OP_UPDATE) && !err) |-> (axis_r <= n_m1))
    else $error("update axis beyond axes in use");
`endif

endmodule

### hdl/particle_swarm_update_engine.sv
// Particle swarm update engine (inertia-weight PSO), top level with APB
// register file. Depends on psu_pkg, psu_ctrl, psu_dp, psu_ram.
//
// Usage:
//  - in_* channel: one beat per operation (set limits, init particle axis,
//    report cost, update particle). out_* channel: result beats; an update
//    yields one beat per axis in use, every other opcode one beat, and the
//    final beat of an item carries last = 1.
//  - cfg_* APB port: axes, w, c1, c2 and target cost at byte offsets 0..16.
//  - One item at a time. Report cost copies the position axis by axis when a
//    best improves; an update runs once per axis in use. The shared multiplier
//    (three products per axis) and the swarm memories, which read and write
//    at one shared address, pace the work.
//  - A finished beat sits in the output register; while the receiver stalls
//    the engine holds and in_ready stays low.
//  - Reset (rst_n low, synchronous) restores register defaults, clears the
//    global best to "none" and its position to zero. Swarm memories are not
//    cleared; set limits and init particles before use.
module particle_swarm_update_engine import psu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t     cfg_r;
  cfg_reg_t reg_sel;
  logic     wr_en;
  cmd_t     cmd;
  stat_t    st;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_reg_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axes_in_use    <= 4'd1;
      cfg_r.inertia_weight <= 16'd11469;
      cfg_r.self_gain      <= 16'd32768;
      cfg_r.swarm_gain     <= 16'd32768;
      cfg_r.target_cost    <= 32'sd0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_AXES:   cfg_r.axes_in_use    <= cfg_pwdata[3:0];
        REG_WEIGHT: cfg_r.inertia_weight <= cfg_pwdata[15:0];
        REG_C1:     cfg_r.self_gain      <= cfg_pwdata[15:0];
        REG_C2:     cfg_r.swarm_gain     <= cfg_pwdata[15:0];
        REG_TARGET: cfg_r.target_cost    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AXES:   cfg_prdata = {28'd0, cfg_r.axes_in_use};
      REG_WEIGHT: cfg_prdata = {16'd0, cfg_r.inertia_weight};
      REG_C1:     cfg_prdata = {16'd0, cfg_r.self_gain};
      REG_C2:     cfg_prdata = {16'd0, cfg_r.swarm_gain};
      REG_TARGET: cfg_prdata = cfg_r.target_cost;
      default:    cfg_prdata = 32'd0;
    endcase
  end

  psu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  psu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

### bench/tb_particle_swarm_update_engine.sv
// Testbench for particle_swarm_update_engine: directed table, then random swarm
// traffic with some bad axes, checked beat by beat against an in-bench predictor.
// Depends on psu_pkg and the engine RTL only.
`timescale 1ns / 100ps

module tb_particle_swarm_update_engine;
  import psu_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  particle_swarm_update_engine DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // configuration mirror
  logic [3:0]         axes_reg;
  logic [15:0]        w_reg, c1_reg, c2_reg;
  logic signed [31:0] target_reg;

  // swarm mirror
  logic signed [31:0] pos_m [MAX_PARTICLES][MAX_AXES];
  logic signed [31:0] vel_m [MAX_PARTICLES][MAX_AXES];
  logic signed [31:0] pbest_pos [MAX_PARTICLES][MAX_AXES];
  logic signed [31:0] pbest_cost [MAX_PARTICLES];
  logic signed [31:0] axis_lo [MAX_AXES];
  logic signed [31:0] axis_hi [MAX_AXES];
  logic signed [31:0] gbest_pos [MAX_AXES];
  logic signed [31:0] gbest_cost;
  bit                 limits_written [MAX_AXES];
  bit                 axis_placed [MAX_PARTICLES][MAX_AXES];

  out_item_t expected_beats [$];
  int        mismatches = 0;
  int        beats_seen = 0;
  int        items_sent = 0;
  int        cycles = 0;
  int        stall_mode = 0;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t exp;
  } row_t;
  row_t directed [$];

  function automatic int axes_eff();
    if (axes_reg == 0) return 1;
    if (axes_reg > MAX_AXES) return MAX_AXES;
    return axes_reg;
  endfunction

  function automatic out_item_t beat(int axis, logic signed [31:0] p, bit st, bit lst);
    out_item_t b;
    b.out_axis = axis[2:0];
    b.new_position = p;
    b.best_cost = gbest_cost;
    b.target_reached = gbest_cost < target_reg;
    b.status = st;
    b.last = lst;
    return b;
  endfunction

  // advances the swarm mirror and queues the beats one item should produce
  task automatic predict_swarm(input in_item_t it);
    int n, p, a;
    longint mn, span, k1, k2, x, v;
    n = axes_eff();
    p = it.particle_index;
    a = it.axis_index;
    if ((it.opcode == OP_LIMITS || it.opcode == OP_INIT) && a >= n) begin
      expected_beats.push_back(beat(a, 0, 1'b1, 1'b1));
      return;
    end
    case (it.opcode)
      OP_LIMITS: begin
        axis_lo[a] = (it.limit_first < it.limit_second) ? it.limit_first : it.limit_second;
        axis_hi[a] = (it.limit_first < it.limit_second) ? it.limit_second : it.limit_first;
        limits_written[a] = 1;
        expected_beats.push_back(beat(a, 0, 1'b0, 1'b1));
      end
      OP_INIT: begin
        mn = axis_lo[a];
        span = longint'(axis_hi[a]) - mn;
        x = mn + ((span * longint'(it.rand_one)) >> 16);
        pos_m[p][a] = x[31:0];
        pbest_pos[p][a] = x[31:0];
        vel_m[p][a] = 0;
        pbest_cost[p] = COST_NONE;
        axis_placed[p][a] = 1;
        expected_beats.push_back(beat(a, x[31:0], 1'b0, 1'b1));
      end
      OP_COST: begin
        if (it.cost < pbest_cost[p]) begin
          pbest_cost[p] = it.cost;
          for (int j = 0; j < n; j++) pbest_pos[p][j] = pos_m[p][j];
        end
        if (it.cost < gbest_cost) begin
          gbest_cost = it.cost;
          for (int j = 0; j < n; j++) gbest_pos[j] = pos_m[p][j];
        end
        expected_beats.push_back(beat(0, 0, 1'b0, 1'b1));
      end
      default: begin
        k1 = (longint'(c1_reg) * longint'(it.rand_one)) >> 16;
        k2 = (longint'(c2_reg) * longint'(it.rand_two)) >> 16;
        for (int j = 0; j < n; j++) begin
          x = pos_m[p][j];
          v = ((longint'(w_reg) * longint'(vel_m[p][j])) >>> 14)
            + ((k1 * (longint'(pbest_pos[p][j]) - x)) >>> 14)
            + ((k2 * (longint'(gbest_pos[j]) - x)) >>> 14);
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          vel_m[p][j] = v[31:0];
          x = x + v;
          if (x > axis_hi[j]) x = axis_hi[j];
          else if (x < axis_lo[j]) x = axis_lo[j];
          pos_m[p][j] = x[31:0];
          expected_beats.push_back(beat(j, x[31:0], 1'b0, j == n - 1));
        end
      end
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        report("unexpected beat", out_data.new_position, 32'd0);
      end else begin
        e = expected_beats.pop_front();
        if (out_data.out_axis !== e.out_axis) report("out_axis", out_data.out_axis, e.out_axis);
        if (out_data.new_position !== e.new_position)
          report("new_position", out_data.new_position, e.new_position);
        if (out_data.best_cost !== e.best_cost) report("best_cost", out_data.best_cost, e.best_cost);
        if (out_data.target_reached !== e.target_reached)
          report("target_reached", out_data.target_reached, e.target_reached);
        if (out_data.status !== e.status) report("status", out_data.status, e.status);
        if (out_data.last !== e.last) report("last", out_data.last, e.last);
      end
    end
  end

  // receiver stall pattern, switched per phase
  always @(posedge clk) begin
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycles % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d beats pending", expected_beats.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input cfg_reg_t r, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(r) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (r)
      REG_AXES:   axes_reg = val[3:0];
      REG_WEIGHT: w_reg = val[15:0];
      REG_C1:     c1_reg = val[15:0];
      REG_C2:     c2_reg = val[15:0];
      default:    target_reg = val;
    endcase
  endtask

  int burst_left = 0;

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t exp);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (stall_mode != 0) repeat ($urandom_range(0, 6)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      predict_swarm(it);
      void'(expected_beats.pop_back());
      expected_beats.push_back(exp);
    end else begin
      predict_swarm(it);
    end
    items_sent++;
    in_valid <= 1'b0;
    // the engine stays busy after taking an item, so this pause costs no rate
    @(posedge clk);
  endtask

  // random item, patched so no store entry is read before it is written
  function automatic in_item_t random_item();
    in_item_t it;
    int n, roll, miss;
    int pool [6] = '{0, 1, 2, 33, 62, 63};
    n = axes_eff();
    it.particle_index = 6'((($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                         : pool[$urandom_range(0, 5)]));
    it.axis_index = 3'($urandom_range(0, n - 1));
    it.limit_first = $urandom;
    it.limit_second = $urandom;
    if ($urandom_range(0, 4) == 0) it.limit_first = 32'h7FFF_FFFF;
    if ($urandom_range(0, 4) == 0) it.limit_second = 32'h8000_0000;
    it.cost = $urandom;
    it.rand_one = 16'($urandom);
    it.rand_two = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      it.opcode = OP_LIMITS;
      if ($urandom_range(0, 2) == 0) it.axis_index = 3'($urandom_range(0, 7));
    end else if (roll < 22) begin
      it.opcode = OP_INIT;
      if ($urandom_range(0, 5) == 0) it.axis_index = 3'($urandom_range(0, 7));
    end else if (roll < 50) it.opcode = OP_COST;
    else it.opcode = OP_UPDATE;
    if (it.opcode == OP_INIT && it.axis_index < n && !limits_written[it.axis_index])
      it.opcode = OP_LIMITS;
    if (it.opcode == OP_COST || it.opcode == OP_UPDATE) begin
      miss = -1;
      for (int j = n - 1; j >= 0; j--)
        if (!axis_placed[it.particle_index][j]) miss = j;
      if (miss >= 0) begin
        it.axis_index = 3'(miss);
        it.opcode = limits_written[miss] ? OP_INIT : OP_LIMITS;
      end
    end
    return it;
  endfunction

  task automatic add_row(input opcode_t op, input int p, input int a, input logic [31:0] lf,
                         input logic [31:0] ls, input logic [31:0] cst, input logic [15:0] r1,
                         input logic [15:0] r2, input bit typed, input out_item_t exp);
    row_t r;
    r.it = '{op, p[5:0], a[2:0], lf, ls, cst, r1, r2};
    r.typed = typed;
    r.exp = exp;
    directed.push_back(r);
  endtask

  task automatic drain();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    out_item_t nx;
    logic [31:0] phase_cfg [5][5];
    nx = '0;
    axes_reg = 4'd1; w_reg = 16'd11469; c1_reg = 16'd32768; c2_reg = 16'd32768;
    target_reg = 0;
    for (int i = 0; i < MAX_AXES; i++) begin
      gbest_pos[i] = 0; limits_written[i] = 0;
      for (int p = 0; p < MAX_PARTICLES; p++) axis_placed[p][i] = 0;
    end
    gbest_cost = COST_NONE;

    // directed table, reset configuration (one axis)
    add_row(OP_LIMITS, 0, 3, 0, 0, 0, 0, 0, 1, '{3'd3, 0, COST_NONE, 1'b0, 1'b1, 1'b1});
    add_row(OP_LIMITS, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1,
            '{3'd0, 0, COST_NONE, 1'b0, 1'b0, 1'b1});
    add_row(OP_INIT, 0, 0, 0, 0, 0, 16'h0000, 0, 1,
            '{3'd0, 32'h8000_0000, COST_NONE, 1'b0, 1'b0, 1'b1});
    add_row(OP_INIT, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0, nx);
    add_row(OP_INIT, 63, 0, 0, 0, 0, 16'h8000, 0, 0, nx);
    add_row(OP_INIT, 5, 1, 0, 0, 0, 16'h1234, 0, 1, '{3'd1, 0, COST_NONE, 1'b0, 1'b1, 1'b1});
    add_row(OP_COST, 0, 0, 0, 0, 100, 0, 0, 0, nx);
    add_row(OP_COST, 63, 0, 0, 0, 100, 0, 0, 0, nx);
    add_row(OP_COST, 63, 0, 0, 0, 32'h8000_0000, 0, 0, 1,
            '{3'd0, 0, 32'h8000_0000, 1'b1, 1'b0, 1'b1});
    add_row(OP_COST, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, nx);
    add_row(OP_UPDATE, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, nx);
    add_row(OP_UPDATE, 63, 0, 0, 0, 0, 16'h0000, 16'h0000, 0, nx);
    add_row(OP_LIMITS, 0, 0, 32'h0005_0000, 32'hFFFB_0000, 0, 0, 0, 0, nx);
    add_row(OP_UPDATE, 0, 0, 0, 0, 0, 16'h8000, 16'h4000, 0, nx);
    add_row(OP_LIMITS, 9, 7, 0, 0, 0, 0, 0, 1, '{3'd7, 0, 32'h8000_0000, 1'b1, 1'b1, 1'b1});
    add_row(OP_INIT, 63, 0, 0, 0, 0, 16'h1234, 0, 0, nx);
    add_row(OP_UPDATE, 63, 0, 0, 0, 0, 16'h5555, 16'hAAAA, 0, nx);
    add_row(OP_UPDATE, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, nx);

    // axes, w, c1, c2, target per phase; includes the extremes
    phase_cfg = '{'{8, 65535, 65535, 65535, 32'h8000_0000},
                  '{0, 0, 0, 0, 32'h7FFF_FFFF},
                  '{15, 16384, 32768, 16384, 0},
                  '{3, 11469, 20000, 40000, 32'hFFF0_0000},
                  '{5, 30000, 65535, 0, 32'h0010_0000}};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].exp);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(REG_AXES, phase_cfg[ph][0]);
      cfg_write(REG_WEIGHT, phase_cfg[ph][1]);
      cfg_write(REG_C1, phase_cfg[ph][2]);
      cfg_write(REG_C2, phase_cfg[ph][3]);
      cfg_write(REG_TARGET, phase_cfg[ph][4]);
      stall_mode = ph % 4;
      for (int k = 0; k < RANDOM_ITEMS / 5; k++) send_item(random_item(), 1'b0, nx);
      drain();
    end

    $display("covered %0d items over 6 register settings, %0d result beats checked",
             items_sent, beats_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
